### rtl/core/bmr_pkg.sv
`default_nettype none

package bmr_pkg;

  // Default sizes of the mailbox
  localparam int RING_DEPTH_DEF      = 64;
  localparam int MAX_SUBSCRIBERS_DEF = 6;
  localparam int PAYLOAD_BITS_DEF    = 32;

  // Fixed field widths
  localparam int ID_BITS     = 22;
  localparam int FUNC_BITS   = 2;
  localparam int STATUS_BITS = 3;

  typedef logic [FUNC_BITS-1:0]   func_t;
  typedef logic [STATUS_BITS-1:0] status_t;
  typedef logic [ID_BITS-1:0]     id_t;

  // Request codes
  localparam func_t FUNC_REGISTER = 2'd0;
  localparam func_t FUNC_POST     = 2'd1;
  localparam func_t FUNC_FETCH    = 2'd2;

  // Result codes
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_FULL  = 3'd1;
  localparam status_t ST_UNREG = 3'd2;
  localparam status_t ST_EMPTY = 3'd3;
  localparam status_t ST_SKIP  = 3'd4;

endpackage

`default_nettype wire

### rtl/core/bmr_if.sv
`default_nettype none

// Request channel
interface bmr_in_if #(
  parameter int PAYLOAD_BITS = bmr_pkg::PAYLOAD_BITS_DEF
);
  import bmr_pkg::*;

  logic                    valid;
  logic                    ready;
  func_t                   func;
  id_t                     requester_id;
  id_t                     target_id;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, output func, output requester_id, output target_id,
                  output payload, input ready);
  modport sink   (input valid, input func, input requester_id, input target_id,
                  input payload, output ready);
endinterface

// Result channel
interface bmr_out_if #(
  parameter int PAYLOAD_BITS = bmr_pkg::PAYLOAD_BITS_DEF
);
  import bmr_pkg::*;

  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [PAYLOAD_BITS-1:0] read_payload;

  modport source (output valid, output status, output read_payload, input ready);
  modport sink   (input valid, input status, input read_payload, output ready);
endinterface

`default_nettype wire

### rtl/core/broadcast_mailbox_ring_core.sv
// Broadcast mailbox ring: a shared message ring with one read head per subscriber.
// in_ch carries one request per beat: func (register, post, fetch), requester_id,
// target_id and payload. out_ch returns exactly one beat per request: status and
// read_payload (payload only on a delivered fetch, else zero).
// A request is taken only while the sequencer is idle. Register, post and unused
// codes pass through the EXEC and DONE states. A fetch walks the subscriber table
// one entry per cycle through a single id comparator, then reads the message ring
// (registered read port) and checks the entry; it goes straight from the search
// to DONE when nothing is pending for the requester or the requester is unknown.
// The sequencer returns to idle once its result is loaded into the output register.
// Results sit in an output register; the next request is taken while a result
// waits there. If the receiver stalls, a second finished result holds in the
// sequencer until the output register frees, and no further request is taken.
// Reset (rst_n low, synchronous) empties the ring tail and the subscriber table
// count; ring slots and table entries are never cleared and need no sweep.
`default_nettype none

module broadcast_mailbox_ring_core #(
  parameter int RING_DEPTH      = bmr_pkg::RING_DEPTH_DEF,
  parameter int MAX_SUBSCRIBERS = bmr_pkg::MAX_SUBSCRIBERS_DEF,
  parameter int PAYLOAD_BITS    = bmr_pkg::PAYLOAD_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  bmr_in_if.sink     in_ch,
  bmr_out_if.source  out_ch
);
  import bmr_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(MAX_SUBSCRIBERS + 1);
  localparam int SW = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // Message ring
  id_t                     msg_sender  [RING_DEPTH];
  id_t                     msg_target  [RING_DEPTH];
  logic [PAYLOAD_BITS-1:0] msg_payload [RING_DEPTH];

  // Subscriber table
  id_t                     sub_ids_r   [MAX_SUBSCRIBERS];
  logic [AW-1:0]           sub_heads_r [MAX_SUBSCRIBERS];
  logic [CW-1:0]           sub_count_r;

  logic [AW-1:0]           ring_tail_r;
  logic [2:0]              state_r, state_nxt;

  // Latched request
  func_t                   req_func_r;
  id_t                     req_who_r;
  id_t                     req_tgt_r;
  logic [PAYLOAD_BITS-1:0] req_payload_r;

  // Fetch working registers
  logic [CW-1:0]           idx_r;
  logic [SW-1:0]           slot_r;
  logic [AW-1:0]           head_r;
  id_t                     rd_sender_r;
  id_t                     rd_target_r;
  logic [PAYLOAD_BITS-1:0] rd_payload_r;

  // Pending result and output register
  status_t                 res_status_r;
  logic [PAYLOAD_BITS-1:0] res_rd_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [PAYLOAD_BITS-1:0] out_rd_r;

  logic                    accept;
  logic                    out_free;
  logic                    idx_live;
  logic                    id_match;
  logic                    table_full;
  logic                    deliver;
  logic [AW-1:0]           tail_inc;
  logic [AW-1:0]           head_inc;
  logic [SW-1:0]           idx_sel;

  assign accept     = in_ch.valid && (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign idx_sel    = idx_r[SW-1:0];
  assign idx_live   = idx_r < sub_count_r;
  assign id_match   = sub_ids_r[idx_sel] == req_who_r;
  assign table_full = sub_count_r >= CW'(MAX_SUBSCRIBERS);
  assign tail_inc   = (ring_tail_r == AW'(RING_DEPTH - 1)) ? '0 : ring_tail_r + AW'(1);
  assign head_inc   = (head_r == AW'(RING_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign deliver    = ((rd_target_r == '0) || (rd_target_r == req_who_r)) &&
                      (rd_sender_r != req_who_r);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.read_payload = out_rd_r;

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = (req_func_r == FUNC_FETCH) ? S_SEARCH : S_DONE;
      S_SEARCH: begin
        if (!idx_live) begin
          state_nxt = S_DONE;
        end else if (id_match) begin
          state_nxt = (sub_heads_r[idx_sel] == ring_tail_r) ? S_DONE : S_READ;
        end
      end
      S_READ:   state_nxt = S_CHECK;
      S_CHECK:  state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ring_tail_r <= '0;
      sub_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC && req_func_r == FUNC_POST) begin
        ring_tail_r <= tail_inc;
      end
      if (state_r == S_EXEC && req_func_r == FUNC_REGISTER && !table_full) begin
        sub_count_r <= sub_count_r + CW'(1);
      end
      // Load a finished beat, else drop a taken one
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func_r    <= in_ch.func;
      req_who_r     <= in_ch.requester_id;
      req_tgt_r     <= in_ch.target_id;
      req_payload_r <= in_ch.payload;
    end

    case (state_r)
      S_EXEC: begin
        idx_r    <= '0;
        res_rd_r <= '0;
        if (req_func_r == FUNC_REGISTER && table_full) begin
          res_status_r <= ST_FULL;
        end else begin
          res_status_r <= ST_OK;
        end
        if (req_func_r == FUNC_REGISTER && !table_full) begin
          sub_ids_r[sub_count_r[SW-1:0]]   <= req_who_r;
          sub_heads_r[sub_count_r[SW-1:0]] <= '0;
        end
      end
      S_SEARCH: begin
        // One table entry per cycle through the shared comparator
        if (!idx_live) begin
          res_status_r <= ST_UNREG;
        end else if (id_match) begin
          slot_r <= idx_sel;
          head_r <= sub_heads_r[idx_sel];
          if (sub_heads_r[idx_sel] == ring_tail_r) begin
            res_status_r <= ST_EMPTY;
          end
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
      S_CHECK: begin
        sub_heads_r[slot_r] <= head_inc;
        if (deliver) begin
          res_status_r <= ST_OK;
          res_rd_r     <= rd_payload_r;
        end else begin
          res_status_r <= ST_SKIP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_rd_r     <= res_rd_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Ring memory: write on post, registered read at the head
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && req_func_r == FUNC_POST) begin
      msg_sender[ring_tail_r]  <= req_who_r;
      msg_target[ring_tail_r]  <= req_tgt_r;
      msg_payload[ring_tail_r] <= req_payload_r;
    end
    if (state_r == S_READ) begin
      rd_sender_r  <= msg_sender[head_r];
      rd_target_r  <= msg_target[head_r];
      rd_payload_r <= msg_payload[head_r];
    end
  end

endmodule

`default_nettype wire
